// ----- rtl/rv32i_subset_core_step_core_defines.svh -----
// ----------------------------------------------------------------------------
// RV32I subset core step: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RV32I_SUBSET_CORE_STEP_CORE_DEFINES_SVH
`define RV32I_SUBSET_CORE_STEP_CORE_DEFINES_SVH

// Same-cycle implication
`define RVCS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define RVCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rvcs_pkg.sv -----
// ----------------------------------------------------------------------------
// rvcs_pkg
// Constants, encodings and shared structures of the RV32I subset core step.
// ----------------------------------------------------------------------------
package rvcs_pkg;

   // Default data memory size in bytes (power of two, at least 16)
   localparam int DATA_MEM_BYTES = 4096;
   // Response queue depth, also the bound on outstanding requests
   localparam int QDEPTH = 4;

   // Opcodes
   localparam logic [6:0] OPC_R    = 7'h33;
   localparam logic [6:0] OPC_I    = 7'h13;
   localparam logic [6:0] OPC_B    = 7'h63;
   localparam logic [6:0] OPC_LW   = 7'h03;
   localparam logic [6:0] OPC_SW   = 7'h23;
   localparam logic [6:0] OPC_JALR = 7'h67;

   // ALU funct3
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // Branch funct3
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // Memory and jump funct3
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_JALR = 3'd0;

   // funct7
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // Register indexes
   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_A0   = 5'd10;
   localparam logic [4:0] REG_A1   = 5'd11;

   // Data memory access from the execute stage
   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      logic [31:0] addr;
      logic [31:0] wdata;
   } dmem_req_type;

   // Execute stage result
   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        wr;
      logic [4:0]  rd;
      logic [31:0] val;
      logic        load;
   } exec_type;

   // Response item
   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_written;
      logic [4:0]  written_index;
      logic [31:0] written_value;
      logic [31:0] a0_value;
      logic [31:0] a1_value;
   } rsp_type;

   // Sign-extend a 12-bit immediate
   function automatic logic [31:0] sext12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

endpackage

// ----- rtl/rvcs_regfile.sv -----
// ----------------------------------------------------------------------------
// rvcs_regfile
// 32 x 32 register file memory, two registered read ports, one write port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rvcs_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b
);

   logic [31:0] mem_ff [32];
   logic [31:0] vld_ff;
   logic [31:0] vld_in;
   logic [31:0] q_a_ff;
   logic [31:0] q_b_ff;
   logic        vld_a_ff;
   logic        vld_b_ff;

   // Write and read the array; a same-edge read returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      q_a_ff <= mem_ff[rd_addr_a];
      q_b_ff <= mem_ff[rd_addr_b];
   end

   // Mark written entries
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         vld_a_ff <= vld_ff[rd_addr_a];
         vld_b_ff <= vld_ff[rd_addr_b];
      end
   end

   // Unwritten entries read as zero
   assign rd_data_a = vld_a_ff ? q_a_ff : '0;
   assign rd_data_b = vld_b_ff ? q_b_ff : '0;

endmodule

// ----- rtl/rvcs_dmem.sv -----
// ----------------------------------------------------------------------------
// rvcs_dmem
// Byte-addressed data memory in four byte banks, little-endian word access
// at any byte offset with wrap-around, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
`include "rv32i_subset_core_step_core_defines.svh"

module rvcs_dmem #(
   parameter int DATA_MEM_BYTES = rvcs_pkg::DATA_MEM_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rvcs_pkg::dmem_req_type req,
   output logic [31:0]            rdata,
   output logic                   busy
);

   localparam int AW   = $clog2(DATA_MEM_BYTES);
   localparam int RW   = AW - 2;
   localparam int ROWS = DATA_MEM_BYTES / 4;

   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [RW-1:0] clr_row_ff;
   logic [RW-1:0] clr_row_in;
   logic [RW-1:0] row_a;
   logic [1:0]    off;
   logic [1:0]    off_ff;
   logic [7:0]    wbyte [4];
   logic [7:0]    rbyte [4];

   // Sweep one row of every bank per cycle after reset
   always_comb begin
      clr_row_in  = clr_row_ff + RW'(1);
      clr_busy_in = clr_busy_ff && (clr_row_ff != RW'(ROWS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   // Split the wrapped address into row and byte offset
   assign row_a = req.addr[AW-1:2];
   assign off   = req.addr[1:0];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         wbyte[k] = req.wdata[8*k +: 8];
      end
   end

   // One bank per byte lane; a lane below the offset takes the next row
   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [7:0]    mem_ff [ROWS];
      logic [7:0]    q_ff;
      logic [RW-1:0] row_j;
      logic [7:0]    data_j;
      logic          we_j;

      always_comb begin
         row_j  = clr_busy_ff ? clr_row_ff : row_a + RW'(2'(j) < off);
         data_j = clr_busy_ff ? 8'h00 : wbyte[2'(j) - off];
         we_j   = clr_busy_ff || req.wr_en;
      end

      always_ff @(posedge clock) begin
         if (we_j) begin
            mem_ff[row_j] <= data_j;
         end
         if (req.rd_en) begin
            q_ff <= mem_ff[row_j];
         end
      end

      assign rbyte[j] = q_ff;
   end

   // Hold the offset of the last read for reassembly
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         off_ff <= off;
      end
   end

   // Rotate bank outputs back into byte order
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rdata[8*k +: 8] = rbyte[2'(k) + off_ff];
      end
   end

   assign busy = clr_busy_ff;

   `RVCS_ASSERT_IMP(a_no_access_in_clear, clr_busy_ff, !req.wr_en && !req.rd_en,
      "data memory accessed during clearing sweep")

endmodule

// ----- rtl/rvcs_exec.sv -----
// ----------------------------------------------------------------------------
// rvcs_exec
// Execute stage: decode, ALU, branch resolution, jump target, halt handling
// and data memory address generation for one instruction.
// ----------------------------------------------------------------------------
module rvcs_exec (
   input  logic [31:0]            ins,
   input  logic [31:0]            pc,
   input  logic                   halt,
   input  logic [31:0]            op_a,
   input  logic [31:0]            op_b,
   output rvcs_pkg::exec_type     res,
   output rvcs_pkg::dmem_req_type mreq
);

   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] immi;
   logic [31:0] imms;
   logic [31:0] offb;
   logic [31:0] pc4;
   logic        reg_form;
   logic        alt;
   logic [31:0] alu_b;
   logic [4:0]  sh;
   logic [31:0] alu_res;
   logic        alu_ok;
   logic        take;
   logic [31:0] npc;
   logic        halt_nx;
   logic        wr;
   logic        load;
   logic [31:0] val;
   logic        wr_q;

   // Decode fields
   assign opc      = ins[6:0];
   assign rd       = ins[11:7];
   assign f3       = ins[14:12];
   assign f7       = ins[31:25];
   assign immi     = rvcs_pkg::sext12(ins[31:20]);
   assign imms     = rvcs_pkg::sext12({ins[31:25], ins[11:7]});
   assign offb     = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
   assign pc4      = pc + 32'd4;
   assign reg_form = (opc == rvcs_pkg::OPC_R);
   assign alt      = (f7 == rvcs_pkg::F7_ALT);

   // Pick the second ALU operand; immediate shifts use the shamt field
   always_comb begin
      if (reg_form) begin
         alu_b = op_b;
      end else if (f3 == rvcs_pkg::F3_SLL || f3 == rvcs_pkg::F3_SR) begin
         alu_b = {27'd0, ins[24:20]};
      end else begin
         alu_b = immi;
      end
   end

   assign sh = alu_b[4:0];

   // ALU
   always_comb begin
      unique case (f3)
         rvcs_pkg::F3_ADD:  alu_res = (reg_form && alt) ? op_a - alu_b : op_a + alu_b;
         rvcs_pkg::F3_SLL:  alu_res = op_a << sh;
         rvcs_pkg::F3_SLT:  alu_res = {31'd0, $signed(op_a) < $signed(alu_b)};
         rvcs_pkg::F3_SLTU: alu_res = {31'd0, op_a < alu_b};
         rvcs_pkg::F3_XOR:  alu_res = op_a ^ alu_b;
         rvcs_pkg::F3_SR:   alu_res = alt ? $unsigned($signed(op_a) >>> sh) : op_a >> sh;
         rvcs_pkg::F3_OR:   alu_res = op_a | alu_b;
         rvcs_pkg::F3_AND:  alu_res = op_a & alu_b;
      endcase
   end

   // Reject undefined funct7 combinations
   always_comb begin
      if (reg_form) begin
         alu_ok = (f7 == rvcs_pkg::F7_BASE) ||
                  (alt && (f3 == rvcs_pkg::F3_ADD || f3 == rvcs_pkg::F3_SR));
      end else begin
         alu_ok = !(f3 == rvcs_pkg::F3_SLL && f7 != rvcs_pkg::F7_BASE) &&
                  !(f3 == rvcs_pkg::F3_SR && f7 != rvcs_pkg::F7_BASE && !alt);
      end
   end

   // Branch condition
   always_comb begin
      unique case (f3)
         rvcs_pkg::F3_BEQ:  take = (op_a == op_b);
         rvcs_pkg::F3_BNE:  take = (op_a != op_b);
         rvcs_pkg::F3_BLT:  take = $signed(op_a) < $signed(op_b);
         rvcs_pkg::F3_BGE:  take = !($signed(op_a) < $signed(op_b));
         rvcs_pkg::F3_BLTU: take = (op_a < op_b);
         rvcs_pkg::F3_BGEU: take = (op_a >= op_b);
         default:           take = 1'b0;
      endcase
   end

   // Sequence the instruction
   always_comb begin
      npc     = pc4;
      halt_nx = halt;
      wr      = 1'b0;
      load    = 1'b0;
      val     = '0;
      mreq    = '0;
      if (halt) begin
         npc = pc;
      end else if (ins == '0) begin
         halt_nx = 1'b1;
      end else begin
         unique case (opc)
            rvcs_pkg::OPC_R, rvcs_pkg::OPC_I: begin
               wr  = alu_ok;
               val = alu_res;
            end
            rvcs_pkg::OPC_B: begin
               if (take) begin
                  npc = pc + offb;
               end
            end
            rvcs_pkg::OPC_LW: begin
               if (f3 == rvcs_pkg::F3_WORD) begin
                  wr         = 1'b1;
                  load       = 1'b1;
                  mreq.rd_en = 1'b1;
                  mreq.addr  = op_a + immi;
               end
            end
            rvcs_pkg::OPC_SW: begin
               if (f3 == rvcs_pkg::F3_WORD) begin
                  mreq.wr_en = 1'b1;
                  mreq.addr  = op_a + imms;
                  mreq.wdata = op_b;
               end
            end
            rvcs_pkg::OPC_JALR: begin
               if (f3 == rvcs_pkg::F3_JALR) begin
                  wr  = 1'b1;
                  val = pc4;
                  npc = (op_a + immi) & ~32'd3;
               end
            end
            default: begin
               npc = pc4;
            end
         endcase
      end
   end

   // Drop writes to x0
   assign wr_q = wr && (rd != rvcs_pkg::REG_ZERO);

   always_comb begin
      res.next_pc = npc;
      res.halted  = halt_nx;
      res.wr      = wr_q;
      res.rd      = wr_q ? rd : rvcs_pkg::REG_ZERO;
      res.val     = wr_q ? val : '0;
      res.load    = wr_q && load;
   end

endmodule

// ----- rtl/rvcs_rspq.sv -----
// ----------------------------------------------------------------------------
// rvcs_rspq
// Response queue between the writeback stage and the response channel.
// ----------------------------------------------------------------------------
`include "rv32i_subset_core_step_core_defines.svh"

module rvcs_rspq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rvcs_pkg::rsp_type push_data,
   input  logic              pop,
   output logic              valid,
   output rvcs_pkg::rsp_type head
);

   localparam int DEPTH = rvcs_pkg::QDEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   rvcs_pkg::rsp_type ent_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW-1:0]     rd_ptr_in;
   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     cnt_in;

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign valid = (cnt_ff != '0);
   assign head  = ent_ff[rd_ptr_ff];

   `RVCS_ASSERT_IMP(a_no_overflow, push, cnt_ff != CW'(DEPTH),
      "response queue written while full")

endmodule

// ----- rtl/rv32i_subset_core_step_core.sv -----
// ----------------------------------------------------------------------------
// rv32i_subset_core_step_core
// RV32I subset core that retires one instruction word per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall/req_instruction) takes the word
//   fetched at the current PC. Response channel (rsp_*) returns one item per
//   request: next PC, halt state, register write and the values of x10/x11.
//   Throughput is one request per cycle while req_stall is low. The
//   register file is read at the accept edge, execute runs in the next
//   cycle, a load's memory read is registered at the end of execute and
//   the response is pushed from writeback, with results forwarded to the
//   execute stage so dependent instructions need no bubble.
//   Responses wait in a four-entry queue; up to four requests may be
//   outstanding, so while the receiver stalls the block keeps accepting
//   until that bound is reached, then raises req_stall.
//   After reset the data memory is cleared one row of four bytes per cycle,
//   with req_stall high throughout. DATA_MEM_BYTES must be a power of two.
// ----------------------------------------------------------------------------
`include "rv32i_subset_core_step_core_defines.svh"

module rv32i_subset_core_step_core #(
   parameter int DATA_MEM_BYTES = rvcs_pkg::DATA_MEM_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_instruction,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_next_pc,
   output logic               rsp_halted,
   output logic               rsp_reg_written,
   output logic [4:0]         rsp_written_index,
   output logic signed [31:0] rsp_written_value,
   output logic signed [31:0] rsp_a0_value,
   output logic signed [31:0] rsp_a1_value
);

   localparam int CW = $clog2(rvcs_pkg::QDEPTH + 1);

   logic                   req_acc;
   logic                   rsp_pop;
   logic [CW-1:0]          inflight_ff;
   logic [CW-1:0]          inflight_in;
   logic                   dmem_busy;
   logic [31:0]            dmem_rdata;
   rvcs_pkg::dmem_req_type ex_mreq;
   rvcs_pkg::dmem_req_type dmem_req;
   rvcs_pkg::exec_type     ex_res;
   logic                   s1_valid_ff;
   logic [31:0]            s1_ins_ff;
   logic [31:0]            rf_a;
   logic [31:0]            rf_b;
   logic [31:0]            op_a;
   logic [31:0]            op_b;
   logic [31:0]            pc_ff;
   logic [31:0]            pc_in;
   logic                   halt_ff;
   logic                   halt_in;
   logic                   s2_valid_ff;
   rvcs_pkg::exec_type     s2_ff;
   logic [31:0]            wb_val;
   logic                   rf_we;
   logic                   s3_wr_ff;
   logic [4:0]             s3_rd_ff;
   logic [31:0]            s3_val_ff;
   logic [31:0]            a0_ff;
   logic [31:0]            a0_in;
   logic [31:0]            a1_ff;
   logic [31:0]            a1_in;
   rvcs_pkg::rsp_type      push_data;
   rvcs_pkg::rsp_type      head;

   // Handshakes and outstanding-request bound
   assign req_stall   = dmem_busy || (inflight_ff == CW'(rvcs_pkg::QDEPTH));
   assign req_acc     = req_valid && !req_stall;
   assign rsp_pop     = rsp_valid && !rsp_stall;
   assign inflight_in = inflight_ff + CW'(req_acc) - CW'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // Register file read at the accept edge
   rvcs_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (req_instruction[19:15]),
      .rd_addr_b (req_instruction[24:20]),
      .wr_en     (rf_we),
      .wr_addr   (s2_ff.rd),
      .wr_data   (wb_val),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   // Execute stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ins_ff <= req_instruction;
      end
   end

   // Forward from writeback, then from the write that landed last edge
   always_comb begin
      priority if (rf_we && s2_ff.rd == s1_ins_ff[19:15]) begin
         op_a = wb_val;
      end else if (s3_wr_ff && s3_rd_ff == s1_ins_ff[19:15]) begin
         op_a = s3_val_ff;
      end else begin
         op_a = rf_a;
      end
      priority if (rf_we && s2_ff.rd == s1_ins_ff[24:20]) begin
         op_b = wb_val;
      end else if (s3_wr_ff && s3_rd_ff == s1_ins_ff[24:20]) begin
         op_b = s3_val_ff;
      end else begin
         op_b = rf_b;
      end
   end

   rvcs_exec u_exec (
      .ins  (s1_ins_ff),
      .pc   (pc_ff),
      .halt (halt_ff),
      .op_a (op_a),
      .op_b (op_b),
      .res  (ex_res),
      .mreq (ex_mreq)
   );

   // Gate memory access with the stage valid
   always_comb begin
      dmem_req       = ex_mreq;
      dmem_req.wr_en = ex_mreq.wr_en && s1_valid_ff;
      dmem_req.rd_en = ex_mreq.rd_en && s1_valid_ff;
   end

   rvcs_dmem #(
      .DATA_MEM_BYTES (DATA_MEM_BYTES)
   ) u_dmem (
      .clock (clock),
      .reset (reset),
      .req   (dmem_req),
      .rdata (dmem_rdata),
      .busy  (dmem_busy)
   );

   // Update PC and halt state in execute order
   assign pc_in   = s1_valid_ff ? ex_res.next_pc : pc_ff;
   assign halt_in = s1_valid_ff ? ex_res.halted : halt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
      end
   end

   // Writeback stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_ff <= ex_res;
      end
   end

   // Select load data or ALU result
   assign wb_val = s2_ff.load ? dmem_rdata : s2_ff.val;
   assign rf_we  = s2_valid_ff && s2_ff.wr;

   // Track the write that lands at this edge for the next execute
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_wr_ff <= 1'b0;
      end else begin
         s3_wr_ff <= rf_we;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         s3_rd_ff  <= s2_ff.rd;
         s3_val_ff <= wb_val;
      end
   end

   // Shadow copies of x10 and x11
   assign a0_in = (rf_we && s2_ff.rd == rvcs_pkg::REG_A0) ? wb_val : a0_ff;
   assign a1_in = (rf_we && s2_ff.rd == rvcs_pkg::REG_A1) ? wb_val : a1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_ff <= '0;
         a1_ff <= '0;
      end else begin
         a0_ff <= a0_in;
         a1_ff <= a1_in;
      end
   end

   // Build the response
   always_comb begin
      push_data.next_pc       = s2_ff.next_pc;
      push_data.halted        = s2_ff.halted;
      push_data.reg_written   = s2_ff.wr;
      push_data.written_index = s2_ff.rd;
      push_data.written_value = wb_val;
      push_data.a0_value      = a0_in;
      push_data.a1_value      = a1_in;
   end

   rvcs_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (push_data),
      .pop       (rsp_pop),
      .valid     (rsp_valid),
      .head      (head)
   );

   assign rsp_next_pc       = head.next_pc;
   assign rsp_halted        = head.halted;
   assign rsp_reg_written   = head.reg_written;
   assign rsp_written_index = head.written_index;
   assign rsp_written_value = $signed(head.written_value);
   assign rsp_a0_value      = $signed(head.a0_value);
   assign rsp_a1_value      = $signed(head.a1_value);

   `RVCS_ASSERT_IMP(a_inflight_bound, 1'b1, inflight_ff <= CW'(rvcs_pkg::QDEPTH),
      "outstanding requests exceed response queue depth")
   `RVCS_ASSERT_NEXT(a_halt_sticky, halt_ff, halt_ff,
      "halt state cleared without reset")
   `RVCS_ASSERT_IMP(a_no_x0_forward, s3_wr_ff, s3_rd_ff != rvcs_pkg::REG_ZERO,
      "write to x0 reached the register file")
   `RVCS_ASSERT_IMP(a_halted_no_write, rsp_valid && rsp_halted, !rsp_reg_written,
      "halted response reports a register write")

endmodule
